@@ rtl/core/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants for the line follower PD steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int LINE_W  = 5;
  localparam int DIST_W  = 10;
  localparam int GAIN_W  = 12;
  localparam int DUTY_W  = 8;
  localparam int ERR_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [GAIN_W-1:0] KP_RESET       = 12'd240;
  localparam logic [GAIN_W-1:0] KD_RESET       = 12'd640;
  localparam logic [DUTY_W-1:0] BASE_RESET     = 8'd80;
  localparam logic [DUTY_W-1:0] STRAIGHT_RESET = 8'd150;
  localparam logic [DIST_W-1:0] STOP_RESET     = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KD_GAIN        = 3'd1,
    REG_BASE_SPEED     = 3'd2,
    REG_STRAIGHT_SPEED = 3'd3,
    REG_STOP_DISTANCE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [DUTY_W-1:0] base_speed;
    logic [DUTY_W-1:0] straight_speed;
    logic [DIST_W-1:0] stop_distance;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] cur_error;
    logic                    lost_flag;
    logic signed [ERR_W-1:0] last_error;
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic                    moving;
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       left_pwm;
    logic [DUTY_W-1:0]       right_pwm;
    logic                    drive_on;
    logic                    obstacle_stop;
    logic signed [ERR_W-1:0] line_error;
    logic                    line_lost;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/lfpd_if.sv @@
// ----------------------------------------------------------------------------
// lfpd_if
// Valid/ready channels for sensor samples and steering results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpd_in_if;
  import lfpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_bits;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, line_bits, distance_cm, input ready);
  modport sink   (input valid, line_bits, distance_cm, output ready);
endinterface

interface lfpd_out_if;
  import lfpd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       left_pwm;
  logic [DUTY_W-1:0]       right_pwm;
  logic                    drive_on;
  logic                    obstacle_stop;
  logic signed [ERR_W-1:0] line_error;
  logic                    line_lost;

  modport source (output valid, left_pwm, right_pwm, drive_on, obstacle_stop,
                  line_error, line_lost, input ready);
  modport sink   (input valid, left_pwm, right_pwm, drive_on, obstacle_stop,
                  line_error, line_lost, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lfpd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lfpd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output lfpd_pkg::cfg_t                        cfg
);
  import lfpd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_KP_GAIN:        cfg_nxt.kp_gain        = cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:        cfg_nxt.kd_gain        = cfg_wdata[GAIN_W-1:0];
        REG_BASE_SPEED:     cfg_nxt.base_speed     = cfg_wdata[DUTY_W-1:0];
        REG_STRAIGHT_SPEED: cfg_nxt.straight_speed = cfg_wdata[DUTY_W-1:0];
        REG_STOP_DISTANCE:  cfg_nxt.stop_distance  = cfg_wdata[DIST_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain        <= KP_RESET;
      cfg_r.kd_gain        <= KD_RESET;
      cfg_r.base_speed     <= BASE_RESET;
      cfg_r.straight_speed <= STRAIGHT_RESET;
      cfg_r.stop_distance  <= STOP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/lfpd_step.sv @@
// ----------------------------------------------------------------------------
// lfpd_step
// One steering step: pattern decode, PD term, duty clamp and state update.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_step (
  input  wire lfpd_pkg::cfg_t                cfg,
  input  wire lfpd_pkg::state_t              st,
  input  wire logic [lfpd_pkg::LINE_W-1:0]   line_bits,
  input  wire logic [lfpd_pkg::DIST_W-1:0]   distance_cm,
  output lfpd_pkg::state_t                   st_nxt,
  output lfpd_pkg::result_t                  res
);
  import lfpd_pkg::*;

  localparam int SUM_W = 18;

  logic                    listed;
  logic signed [ERR_W-1:0] dec_err;
  logic                    obstacle;
  logic signed [ERR_W-1:0] err_new;
  logic                    lost_new;
  logic signed [4:0]       err_diff;
  logic signed [SUM_W-1:0] kp_term;
  logic signed [SUM_W-1:0] kd_term;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] base_q4;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] right_sum;
  logic [DUTY_W-1:0]       left_clamp;
  logic [DUTY_W-1:0]       right_clamp;

  function automatic logic [DUTY_W-1:0] duty_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-6:0] q;
    q = s[SUM_W-2:4];
    if (s[SUM_W-1]) begin
      duty_clamp = '0;
    end else if (q > (SUM_W-5)'(255)) begin
      duty_clamp = '1;
    end else begin
      duty_clamp = q[DUTY_W-1:0];
    end
  endfunction

  always_comb begin
    listed  = 1'b1;
    dec_err = '0;
    case (line_bits)
      5'd1:    dec_err = -4'sd4;
      5'd3:    dec_err = -4'sd3;
      5'd2:    dec_err = -4'sd2;
      5'd6:    dec_err = -4'sd1;
      5'd4:    dec_err = 4'sd0;
      5'd12:   dec_err = 4'sd1;
      5'd8:    dec_err = 4'sd2;
      5'd24:   dec_err = 4'sd3;
      5'd16:   dec_err = 4'sd4;
      default: listed  = 1'b0;
    endcase
  end

  assign obstacle = !(distance_cm > cfg.stop_distance);

  always_comb begin
    err_new  = st.cur_error;
    lost_new = st.lost_flag;
    if (line_bits == '0) begin
      err_new  = '0;
      lost_new = 1'b1;
    end else if (listed) begin
      err_new  = dec_err;
      lost_new = 1'b0;
    end
  end

  // Q14.4 PD term, gains zero extended and errors sign extended to the sum width
  assign err_diff = {err_new[ERR_W-1], err_new} - {st.last_error[ERR_W-1], st.last_error};
  assign kp_term  = $signed({6'd0, cfg.kp_gain}) *
                    $signed({{(SUM_W-ERR_W){err_new[ERR_W-1]}}, err_new});
  assign kd_term  = $signed({6'd0, cfg.kd_gain}) *
                    $signed({{(SUM_W-5){err_diff[4]}}, err_diff});
  assign term     = kp_term + kd_term;
  assign base_q4  = $signed({6'd0, cfg.base_speed, 4'd0});
  assign left_sum  = base_q4 + term;
  assign right_sum = base_q4 - term;
  assign left_clamp  = duty_clamp(left_sum);
  assign right_clamp = duty_clamp(right_sum);

  always_comb begin
    st_nxt = st;
    if (obstacle) begin
      st_nxt.moving = 1'b0;
    end else begin
      st_nxt.moving    = 1'b1;
      st_nxt.cur_error = err_new;
      st_nxt.lost_flag = lost_new;
      if (lost_new) begin
        // keep held duties
      end else if (err_new == '0) begin
        st_nxt.left_duty  = cfg.straight_speed;
        st_nxt.right_duty = cfg.straight_speed;
      end else begin
        st_nxt.left_duty  = left_clamp;
        st_nxt.right_duty = right_clamp;
        st_nxt.last_error = err_new;
      end
    end
  end

  always_comb begin
    res.left_pwm      = st_nxt.left_duty;
    res.right_pwm     = st_nxt.right_duty;
    res.drive_on      = st_nxt.moving;
    res.obstacle_stop = obstacle;
    res.line_error    = st_nxt.cur_error;
    res.line_lost     = st_nxt.lost_flag;
  end

endmodule

`default_nettype wire

@@ rtl/core/line_follow_pd_steering_top.sv @@
// ----------------------------------------------------------------------------
// line_follow_pd_steering_top
// Line follower PD steering: sensor samples in, motor duties out.
// ----------------------------------------------------------------------------
// path: a transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while the result channel is ready, set by the input and result registers
// reset (synchronous, rst_n low): channels empty, registers to their defaults,
// error, duties and drive state cleared to zero
`default_nettype none

module line_follow_pd_steering_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  lfpd_in_if.sink                               in_chan,
  lfpd_out_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lfpd_pkg::*;

  cfg_t    cfg;
  state_t  state_r, state_nxt;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_v_r;
  logic    s1_v_r;
  logic [LINE_W-1:0] s1_line_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic    out_free;
  logic    s1_move;
  logic    in_take;

  lfpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfpd_step u_step (
    .cfg         (cfg),
    .st          (state_r),
    .line_bits   (s1_line_r),
    .distance_cm (s1_dist_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  assign out_free = !out_v_r || out_chan.ready;
  assign s1_move  = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || out_free;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_v_r <= in_chan.valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      // state advances only when the transaction moves into the result register
      if (s1_move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_line_r <= in_chan.line_bits;
      s1_dist_r <= in_chan.distance_cm;
    end
    if (s1_move) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.left_pwm      = out_res_r.left_pwm;
  assign out_chan.right_pwm     = out_res_r.right_pwm;
  assign out_chan.drive_on      = out_res_r.drive_on;
  assign out_chan.obstacle_stop = out_res_r.obstacle_stop;
  assign out_chan.line_error    = out_res_r.line_error;
  assign out_chan.line_lost     = out_res_r.line_lost;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for line_follow_pd_steering_top. Directed and random sensor
// samples are driven in bursts against a stalling result channel. Each
// steering result is checked field by field against a PD steering predictor
// kept in a scoreboard, across several register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RUN_ITEMS   = 140;
  localparam int DIST_MAX    = (1 << DIST_W) - 1;
  localparam int SETTLE      = 4;
  localparam int REPORT_MAX  = 10;

  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_RUNS} rx_mode_t;

  // steering predictor plus the queue of results still owed by the block
  class steering_scoreboard;
    int kp, kd, base, straight, stop;
    int err_now, err_prev;
    bit lost;
    int left_d, right_d;
    bit moving;
    result_t pending[$];
    int mismatches;

    function new();
      kp = KP_RESET;
      kd = KD_RESET;
      base = BASE_RESET;
      straight = STRAIGHT_RESET;
      stop = STOP_RESET;
      err_now = 0;
      err_prev = 0;
      lost = 0;
      left_d = 0;
      right_d = 0;
      moving = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KP_GAIN:        kp = val[GAIN_W-1:0];
        REG_KD_GAIN:        kd = val[GAIN_W-1:0];
        REG_BASE_SPEED:     base = val[DUTY_W-1:0];
        REG_STRAIGHT_SPEED: straight = val[DUTY_W-1:0];
        REG_STOP_DISTANCE:  stop = val[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // q4 sum to duty: negative clamps to zero, truncate, saturate high
    static function int clamp_duty(int q4_sum);
      if (q4_sum < 0) return 0;
      if (q4_sum / 16 > 255) return 255;
      return q4_sum / 16;
    endfunction

    function void note_sample(logic [LINE_W-1:0] pat, logic [DIST_W-1:0] dist_cm);
      result_t due;
      int e;
      int term;
      bit known;
      bit halted;
      halted = 0;
      if (int'(dist_cm) > stop) begin
        known = 1;
        e = 0;
        case (pat)
          5'b00001: e = -4;
          5'b00011: e = -3;
          5'b00010: e = -2;
          5'b00110: e = -1;
          5'b00100: e = 0;
          5'b01100: e = 1;
          5'b01000: e = 2;
          5'b11000: e = 3;
          5'b10000: e = 4;
          default:  known = 0;
        endcase
        if (pat == '0) begin
          err_now = 0;
          lost = 1;
        end else if (known) begin
          err_now = e;
          lost = 0;
        end
        // line lost keeps the held duties
        if (!lost) begin
          if (err_now == 0) begin
            left_d = straight;
            right_d = straight;
          end else begin
            term = kp * err_now + kd * (err_now - err_prev);
            left_d = clamp_duty(base * 16 + term);
            right_d = clamp_duty(base * 16 - term);
            err_prev = err_now;
          end
        end
        moving = 1;
      end else begin
        moving = 0;
        halted = 1;
      end
      due.left_pwm = left_d[DUTY_W-1:0];
      due.right_pwm = right_d[DUTY_W-1:0];
      due.drive_on = moving;
      due.obstacle_stop = halted;
      due.line_error = err_now[ERR_W-1:0];
      due.line_lost = lost;
      pending.push_back(due);
    endfunction

    function void check_result(result_t got);
      result_t due;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result L=%0d R=%0d drv=%0b stop=%0b err=%0d lost=%0b",
                   $time, got.left_pwm, got.right_pwm, got.drive_on, got.obstacle_stop,
                   got.line_error, got.line_lost);
        return;
      end
      due = pending.pop_front();
      if (got.left_pwm !== due.left_pwm || got.right_pwm !== due.right_pwm ||
          got.drive_on !== due.drive_on || got.obstacle_stop !== due.obstacle_stop ||
          got.line_error !== due.line_error || got.line_lost !== due.line_lost) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: mismatch expected L=%0d R=%0d drv=%0b stop=%0b err=%0d lost=%0b",
                   $time, due.left_pwm, due.right_pwm, due.drive_on, due.obstacle_stop,
                   due.line_error, due.line_lost);
          $display("%0t:          actual   L=%0d R=%0d drv=%0b stop=%0b err=%0d lost=%0b",
                   $time, got.left_pwm, got.right_pwm, got.drive_on, got.obstacle_stop,
                   got.line_error, got.line_lost);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lfpd_in_if  in_ch ();
  lfpd_out_if out_ch ();

  line_follow_pd_steering_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  steering_scoreboard sb = new();

  logic [LINE_W-1:0] listed_pat [9] = '{5'd1, 5'd3, 5'd2, 5'd6, 5'd4, 5'd12, 5'd8, 5'd24,
                                        5'd16};

  // centered, every listed error, line lost, unknown patterns while lost and
  // after an error, distance at and just above the stop distance, no echo
  int dir_line [20] = '{4, 1, 3, 2, 6, 12, 8, 24, 16, 0, 5, 31, 16, 1, 1, 10, 4, 0, 24, 31};
  int dir_dist [20] = '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
                        1023, 11, 10, 0, 512, 700, 11, 11, 1023, 31};

  int burst_left = 0;
  int unsigned cycles = 0;
  result_t seen;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("line_follow_pd_steering_top verification failed");
      $finish;
    end
  end

  // result channel: ready pattern switches between stall modes
  initial begin
    rx_mode_t mode;
    int mode_left;
    int run_left;
    logic hold;
    mode = RX_OPEN;
    mode_left = 0;
    run_left = 0;
    hold = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 4) != 0);
        default: begin
          if (run_left == 0) begin
            hold = ~hold;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_ch.ready <= hold;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.left_pwm = out_ch.left_pwm;
      seen.right_pwm = out_ch.right_pwm;
      seen.drive_on = out_ch.drive_on;
      seen.obstacle_stop = out_ch.obstacle_stop;
      seen.line_error = out_ch.line_error;
      seen.line_lost = out_ch.line_lost;
      sb.check_result(seen);
    end
  end

  // one sensor transaction, then maybe a gap between bursts
  task automatic send_sample(logic [LINE_W-1:0] pat, logic [DIST_W-1:0] dist_cm);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.line_bits <= pat;
    in_ch.distance_cm <= dist_cm;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(pat, dist_cm);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // mostly tracked-line patterns, some line lost, some unknown, and
  // distances biased around the stop threshold; drains at the end
  task automatic run_random(int count);
    logic [LINE_W-1:0] pat;
    logic [DIST_W-1:0] dist_cm;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) pat = listed_pat[$urandom_range(0, 8)];
      else if (pick < 77) pat = '0;
      else pat = LINE_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (sb.stop >= DIST_MAX || pick < 10) dist_cm = DIST_W'($urandom_range(0, sb.stop));
      else if (pick < 14) dist_cm = DIST_W'(sb.stop);
      else if (pick < 18) dist_cm = DIST_W'(sb.stop + 1);
      else dist_cm = DIST_W'($urandom_range(sb.stop + 1, DIST_MAX));
      send_sample(pat, dist_cm);
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // writes every register index, unused ones with junk that must be ignored
  task automatic load_settings(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] kd,
                               logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] straight,
                               logic [CFG_DATA_W-1:0] stop);
    logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
    foreach (vals[i]) vals[i] = CFG_DATA_W'($urandom);
    vals[REG_KP_GAIN] = kp;
    vals[REG_KD_GAIN] = kd;
    vals[REG_BASE_SPEED] = base;
    vals[REG_STRAIGHT_SPEED] = straight;
    vals[REG_STOP_DISTANCE] = stop;
    foreach (vals[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.line_bits <= '0;
    in_ch.distance_cm <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_line[i]) send_sample(LINE_W'(dir_line[i]), DIST_W'(dir_dist[i]));
    run_random(RUN_ITEMS);

    // gains and speeds at full scale, stop only on no echo
    load_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'h0FF, 12'h000);
    run_random(RUN_ITEMS);
    // everything zero
    load_settings(12'h000, 12'h000, 12'h000, 12'h000, 12'h000);
    run_random(100);
    // stop distance at its top: every sample is an obstacle
    load_settings(12'h0F0, 12'h280, 12'h050, 12'h096, 12'hFFF);
    run_random(40);
    repeat (6) begin
      load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 300)));
      run_random(RUN_ITEMS);
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("line_follow_pd_steering_top verification clean");
    end else begin
      $display("line_follow_pd_steering_top verification failed");
    end
    $finish;
  end

endmodule
